@@ hdl/anbsplit_pkg.sv @@
// shared types and constants for the annex b nal unit splitter
package anbsplit_pkg;

    localparam int POS_BITS    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    // one finished unit as the parser sees it, before type decoding
    typedef struct packed {
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] length;
        logic                long_prefix;
        logic [7:0]          header;
        logic                last;
    } desc_t;

endpackage

@@ hdl/anbsplit_front.sv @@
// start code parser: accepts bytes and produces unit descriptors
module anbsplit_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_data,
    input  logic                s_last,
    input  logic                q_full,
    output logic                q_push,
    output anbsplit_pkg::desc_t q_desc
);
    import anbsplit_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [1:0]          zr_reg, zr_next;
    logic                open_reg, open_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic                long_reg, long_next;
    logic [7:0]          hdr_reg, hdr_next;
    logic                want_reg, want_next;
    logic                pend_reg, pend_next;
    desc_t               pend_desc_reg, pend_desc_next;

    logic                accept;
    logic [7:0]          hdr_cur;
    logic                start_code;
    logic                lng;
    logic [POS_BITS-1:0] back_amt;
    logic [POS_BITS-1:0] pstart;
    logic [POS_BITS-1:0] a_len;
    logic [POS_BITS-1:0] diff;
    logic [POS_BITS-1:0] b_len;
    logic                a_valid, b_valid;
    desc_t               a_desc, b_desc;

    assign s_tready = !pend_reg && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        hdr_cur    = (open_reg && want_reg) ? s_data : hdr_reg;
        start_code = (s_data == BYTE_ONE) && (zr_reg >= 2'd2);
        lng        = (zr_reg == 2'd3);
        back_amt   = lng ? POS_BITS'(3) : POS_BITS'(2);
        pstart     = (pos_reg >= back_amt) ? pos_reg - back_amt : '0;
        a_len      = (pstart >= start_reg) ? pstart - start_reg : '0;
        diff       = (pos_reg >= start_reg) ? pos_reg - start_reg : '0;

        pos_next   = pos_reg;
        zr_next    = zr_reg;
        open_next  = open_reg;
        start_next = start_reg;
        long_next  = long_reg;
        hdr_next   = hdr_cur;
        want_next  = want_reg && !open_reg;

        if (start_code) begin
            open_next  = 1'b1;
            start_next = pstart;
            long_next  = lng;
            hdr_next   = BYTE_ZERO;
            want_next  = 1'b1;
            zr_next    = 2'd0;
        end else if (s_data == BYTE_ZERO) begin
            zr_next = (zr_reg == 2'd3) ? 2'd3 : zr_reg + 2'd1;
        end else begin
            zr_next = 2'd0;
        end

        // closing length at the final byte of a buffer
        if (start_code) begin
            b_len = (pos_reg >= back_amt) ? back_amt + POS_BITS'(1) : pos_reg + POS_BITS'(1);
        end else begin
            b_len = (diff == POS_MAX) ? POS_MAX : diff + POS_BITS'(1);
        end

        a_valid = start_code && open_reg;
        b_valid = s_last && open_next;

        a_desc.start       = start_reg;
        a_desc.length      = a_len;
        a_desc.long_prefix = long_reg;
        a_desc.header      = hdr_cur;
        a_desc.last        = !b_valid;

        b_desc.start       = start_next;
        b_desc.length      = b_len;
        b_desc.long_prefix = long_next;
        b_desc.header      = hdr_next;
        b_desc.last        = 1'b1;

        if (s_last) begin
            pos_next  = '0;
            zr_next   = 2'd0;
            open_next = 1'b0;
            want_next = 1'b0;
        end else begin
            pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_BITS'(1);
        end

        pend_next      = pend_reg;
        pend_desc_next = pend_desc_reg;
        q_push         = 1'b0;
        q_desc         = a_valid ? a_desc : b_desc;
        if (pend_reg) begin
            q_desc = pend_desc_reg;
            if (!q_full) begin
                q_push    = 1'b1;
                pend_next = 1'b0;
            end
        end else if (accept) begin
            q_push = a_valid || b_valid;
            if (a_valid && b_valid) begin
                pend_next      = 1'b1;
                pend_desc_next = b_desc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            zr_reg    <= 2'd0;
            open_reg  <= 1'b0;
            start_reg <= '0;
            long_reg  <= 1'b0;
            hdr_reg   <= BYTE_ZERO;
            want_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (accept) begin
                pos_reg   <= pos_next;
                zr_reg    <= zr_next;
                open_reg  <= open_next;
                start_reg <= start_next;
                long_reg  <= long_next;
                hdr_reg   <= hdr_next;
                want_reg  <= want_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_desc_reg <= pend_desc_next;
    end

    // second descriptor of a byte is always the closing one
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> pend_desc_reg.last)
        else $error("pending descriptor not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && a_valid && b_valid) |=> pend_reg)
        else $error("second descriptor dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last) |=> (pos_reg == '0 && !open_reg))
        else $error("buffer end did not restart position");

endmodule

@@ hdl/anbsplit_queue.sv @@
// short descriptor queue between parser and output stage
module anbsplit_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  anbsplit_pkg::desc_t push_desc,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output anbsplit_pkg::desc_t head_desc
);
    import anbsplit_pkg::*;

    desc_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_desc = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

@@ hdl/anbsplit_back.sv @@
// type decoding and output register for finished units
module anbsplit_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                q_not_empty,
    input  anbsplit_pkg::desc_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,
    output logic                m_tlast
);
    import anbsplit_pkg::*;

    logic        codec_reg;
    logic        valid_reg, valid_next;
    logic [71:0] data_reg, data_next;
    logic        last_reg, last_next;

    logic [POS_BITS-1:0] plen;
    logic [5:0]          utype;
    logic                ok;
    logic [5:0]          t265;
    logic [5:0]          t264;

    always_comb begin
        plen  = q_head.long_prefix ? POS_BITS'(4) : POS_BITS'(3);
        t265  = q_head.header[6:1];
        t264  = {1'b0, q_head.header[4:0]};
        utype = 6'd0;
        ok    = 1'b0;
        if (q_head.length > plen) begin
            if (codec_reg == CODEC_H265) begin
                utype = t265;
                ok    = (t265 != 6'd35) && (t265 <= 6'd39);
            end else begin
                utype = t264;
                ok    = (t264 != 6'd0) && (t264 != 6'd6) && (t264 != 6'd9) && (t264 <= 6'd21);
            end
            if (q_head.length <= plen + POS_BITS'(1)) begin
                ok = 1'b0;
            end
        end

        q_pop      = q_not_empty && (!valid_reg || m_tready);
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        if (q_pop) begin
            valid_next = 1'b1;
            data_next  = {ok, utype, q_head.long_prefix, q_head.length, q_head.start};
            last_next  = q_head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg <= CODEC_H264;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_wr_en) begin
                codec_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[71]) |-> (m_tdata[63:32] > 32'd4))
        else $error("supported unit too short");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[63:32] <= 32'd3) |-> (m_tdata[70:65] == 6'd0))
        else $error("type set on unit without header");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_tvalid)
        else $error("popped descriptor not presented");

endmodule

@@ hdl/annexb_nal_unit_splitter.sv @@
// top level of the annex b nal unit splitter
//
// input channel s_*: one stream byte per transfer, s_tlast on the final
// byte of a buffer. the byte after s_tlast is offset 0 of a new buffer.
// result channel m_*: one descriptor per nal unit, sent when the unit ends
// at the next start code or at the buffer's final byte; m_tlast marks the
// final descriptor caused by one input byte.
// cfg_wr_en / cfg_wr_data set the codec: 0 for h.264 type rules, 1 for h.265.
// throughput: one byte per cycle while the queue has room; a byte that closes two units (start code
// on the final byte) holds s_tready low until its second descriptor is queued.
// a descriptor goes from the byte that closes it to m_* through a queue write,
// then a decode into the output register.
// a four-entry descriptor queue lets the parser keep taking bytes while
// the receiver stalls; s_tready also drops when that queue is full.
// reset (aresetn low, synchronous) clears position, parser state, queue,
// output valid and selects h.264.
module annexb_nal_unit_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // unit_start, unit_length, long_prefix, unit_type, supported
    output logic        m_tlast
);
    import anbsplit_pkg::*;

    logic  q_push;
    desc_t q_push_desc;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;
    desc_t q_head;

    anbsplit_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_data   (s_tdata),
        .s_last   (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (q_push_desc)
    );

    anbsplit_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_desc (q_head)
    );

    anbsplit_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
